// ----- hdl/vsptb_pkg.sv -----
package vsptb_pkg;

  // Width of the loop counter reported on cycle_count
  localparam int CYCLE_BITS = 32;

  // Width of the phase output port
  localparam int PHASE_OUT_BITS = 16;

  // Speed is given in percent
  localparam logic [6:0] PCT_SCALE = 7'd100;

  // Result action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_REDRAW  = 2'd1;
  localparam logic [1:0] ACT_WRAP    = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  // Input cmd field codes
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_CONTROL = 1'b1;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_RESTART,
    DP_PAUSE_TICK,
    DP_MUL_DIFF,
    DP_MUL_POS,
    DP_POS_HUNDRED,
    DP_E_HUNDRED,
    DP_DIV_E,
    DP_DIV_MOD,
    DP_DIV_SCALE,
    DP_TICK,
    DP_FREEZE,
    DP_REBASE,
    DP_EMIT
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic cmd;
    logic have;
    logic pat_match;
    logic spd_same;
    logic spd_zero;
    logic speed_zero;
    logic div_busy;
  } dp_status_t;

endpackage

// ----- hdl/variable_speed_phase_timebase_core.sv -----
// Speed-scaled animation timebase.
// Input channel (in_valid / in_stall): one transaction per item. cmd = 1 is a
// control update (pattern_select, speed_pct); cmd = 0 is a tick that turns
// now_ms into a phase within loop_length and a completed-loop count.
// Output channel (out_valid / out_stall): exactly one result per item, with
// action, phase and cycle_count.
// Items are handled one at a time by a controller and a datapath with a
// multi-cycle reciprocal multiply for the divide by 100 and one shared radix-2
// divider for the loop length and speed divisions, one quotient bit per cycle.
// Restart, unchanged control, paused tick and tick without pattern skip the
// arithmetic; a running tick or pause uses the reciprocal multiply and then the
// divider, a resume from pause the times-100 step and the divider, and any other
// speed change the reciprocal multiply, the times-100 step and then the divider.
// A new item is taken in the cycle after its predecessor's result is queued.
// The result sits in an output register; while out_stall holds it, the block
// still accepts and works the next item and waits only to hand over its result.
// Reset (rst, synchronous) clears the timebase: no pattern, phase 0, count 0;
// a tick before the first control update reports action none.
module variable_speed_phase_timebase_core #(
  parameter int TIME_BITS   = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd,
  input  logic [TIME_BITS-1:0]   now_ms,
  input  logic [7:0]             speed_pct,
  input  logic [7:0]             pattern_select,
  input  logic [LENGTH_BITS-1:0] loop_length,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             action,
  output logic [15:0]            phase,
  output logic [31:0]            cycle_count
);
  import vsptb_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  vsptb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .op        (op)
  );

  vsptb_dpath #(
    .TIME_BITS   (TIME_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .status         (status),
    .cmd            (cmd),
    .now_ms         (now_ms),
    .speed_pct      (speed_pct),
    .pattern_select (pattern_select),
    .loop_length    (loop_length),
    .action         (action),
    .phase          (phase),
    .cycle_count    (cycle_count)
  );

endmodule

// ----- hdl/vsptb_dpath.sv -----
module vsptb_dpath #(
  parameter int TIME_BITS   = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  vsptb_pkg::dp_op_t      op,
  output vsptb_pkg::dp_status_t  status,
  input  logic                   cmd,
  input  logic [TIME_BITS-1:0]   now_ms,
  input  logic [7:0]             speed_pct,
  input  logic [7:0]             pattern_select,
  input  logic [LENGTH_BITS-1:0] loop_length,
  output logic [1:0]             action,
  output logic [15:0]            phase,
  output logic [31:0]            cycle_count
);
  import vsptb_pkg::*;

  localparam int TW    = TIME_BITS;
  localparam int LB    = LENGTH_BITS;
  localparam int MW    = TW + 8;                       // (now - start) * speed
  localparam int EW    = TW + 2;                       // scaled elapsed time
  localparam int PW    = CYCLE_BITS + LB;              // cycle * length + phase
  localparam int SW    = ((EW > PW) ? EW : PW) + 7;    // anything times 100
  localparam int DIV_W = SW;
  localparam int DVW   = (LB > 8) ? LB : 8;
  localparam int CW    = $clog2(DIV_W + 1);
  localparam int SH_M  = DIV_W - EW;
  localparam int PX    = (LB > PHASE_OUT_BITS) ? LB : PHASE_OUT_BITS;

  // Divide by 100 as a multiply by ceil(2^RK / 100), 16 reciprocal bits a cycle;
  // exact for dividends below 2^MW since the rounding error stays under 2^7
  localparam int RK    = MW + 7;
  localparam int RC    = (MW + 16) / 16;
  localparam int RW    = 16 * RC;
  localparam int AW    = MW + RW;
  localparam int PRW   = MW + 16;
  localparam int MCW   = $clog2(RC + 1);
  localparam logic [63:0] RECIP = ((64'd1 << RK) + 64'd99) / 64'd100;

  // Timebase state
  logic            st_have;
  logic [7:0]      st_pid;
  logic [TW-1:0]   st_start;
  logic [LB-1:0]   st_phase;
  logic [CYCLE_BITS-1:0] st_cycle;
  logic [7:0]      st_speed;

  // Captured transaction
  logic            in_cmd;
  logic [TW-1:0]   in_now;
  logic [7:0]      in_spd;
  logic [7:0]      in_sel;
  logic [LB-1:0]   in_dur;

  // Work registers
  logic [DIV_W-1:0] prod;
  logic [1:0]       act;

  // Reciprocal multiply for the divide by 100
  logic [AW-1:0]    acc;
  logic [RW-1:0]    rcp;
  logic [MCW-1:0]   mcnt;
  logic [PRW-1:0]   rcp_part;
  logic [EW-1:0]    e_val;

  // Shared restoring divider
  logic [DIV_W-1:0] quo;
  logic [DVW-1:0]   rem;
  logic [DVW-1:0]   divisor;
  logic [CW-1:0]    cnt;
  logic [DVW:0]     trial;
  logic [DVW:0]     diff_rem;
  logic             take;

  // Arithmetic ahead of the work registers
  logic [TW-1:0]  elapsed;
  logic [MW-1:0]  mul_diff;
  logic [PW-1:0]  mul_pos;
  logic [SW-1:0]  pos_hundred;
  logic [SW-1:0]  e_hundred;
  logic [PX-1:0]  phase_ext;

  assign elapsed     = in_now - st_start;
  assign mul_diff    = MW'(elapsed) * MW'(st_speed);
  assign mul_pos     = PW'(st_cycle) * PW'(in_dur) + PW'(st_phase);
  assign pos_hundred = SW'(prod[PW-1:0]) * SW'(PCT_SCALE);
  assign e_hundred   = SW'(e_val) * SW'(PCT_SCALE);
  assign phase_ext   = PX'(st_phase);

  assign rcp_part = PRW'(prod[MW-1:0]) * PRW'(rcp[RW-1 -: 16]);
  assign e_val    = acc[RK +: EW];

  assign trial    = {rem, quo[DIV_W-1]};
  assign diff_rem = trial - {1'b0, divisor};
  assign take     = (trial >= {1'b0, divisor});

  // Status to controller
  assign status.cmd        = in_cmd;
  assign status.have       = st_have;
  assign status.pat_match  = (in_sel == st_pid);
  assign status.spd_same   = (in_spd == st_speed);
  assign status.spd_zero   = (in_spd == 8'd0);
  assign status.speed_zero = (st_speed == 8'd0);
  assign status.div_busy   = (cnt != '0) || (mcnt != '0);

  // Timebase state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      st_have  <= 1'b0;
      st_pid   <= '0;
      st_start <= '0;
      st_phase <= '0;
      st_cycle <= '0;
      st_speed <= '0;
    end else begin
      unique case (op)
        DP_RESTART: begin
          st_have  <= 1'b1;
          st_pid   <= in_sel;
          st_start <= in_now;
          st_phase <= '0;
          st_cycle <= '0;
          st_speed <= in_spd;
        end
        DP_TICK: begin
          st_phase <= rem[LB-1:0];
          st_cycle <= quo[CYCLE_BITS-1:0];
        end
        DP_FREEZE: begin
          st_phase <= rem[LB-1:0];
          st_speed <= in_spd;
        end
        DP_REBASE: begin
          st_start <= in_now - quo[TW-1:0];
          st_speed <= in_spd;
        end
        default: begin
        end
      endcase
    end
  end

  // Capture, products, action and result registers
  always_ff @(posedge clk) begin
    unique case (op)
      DP_CAPTURE: begin
        in_cmd <= cmd;
        in_now <= now_ms;
        in_spd <= speed_pct;
        in_sel <= pattern_select;
        in_dur <= (loop_length == '0) ? LB'(1) : loop_length;
        act    <= ACT_NONE;
      end
      DP_RESTART:     act  <= ACT_RESTART;
      DP_PAUSE_TICK:  act  <= ACT_REDRAW;
      DP_TICK:        act  <= (quo[CYCLE_BITS-1:0] != st_cycle) ? ACT_WRAP : ACT_REDRAW;
      DP_MUL_DIFF:    prod <= DIV_W'(mul_diff);
      DP_MUL_POS:     prod <= DIV_W'(mul_pos);
      DP_POS_HUNDRED: prod <= pos_hundred;
      DP_E_HUNDRED:   prod <= e_hundred;
      DP_EMIT: begin
        action      <= act;
        phase       <= phase_ext[PHASE_OUT_BITS-1:0];
        cycle_count <= st_cycle;
      end
      default: begin
      end
    endcase
  end

  // Reciprocal step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
    end else if (op == DP_DIV_E) begin
      mcnt <= MCW'(RC);
    end else if (mcnt != '0) begin
      mcnt <= mcnt - MCW'(1);
    end
  end

  // Scaled elapsed time: multiply-accumulate, top reciprocal chunk first
  always_ff @(posedge clk) begin
    if (op == DP_DIV_E) begin
      acc <= '0;
      rcp <= RW'(RECIP);
    end else if (mcnt != '0) begin
      acc <= {acc[AW-17:0], 16'd0} + AW'(rcp_part);
      rcp <= {rcp[RW-17:0], 16'd0};
    end
  end

  // Divider step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case (op)
        DP_DIV_MOD:   cnt <= CW'(EW);
        DP_DIV_SCALE: cnt <= CW'(DIV_W);
        default: begin
          if (cnt != '0) begin
            cnt <= cnt - CW'(1);
          end
        end
      endcase
    end
  end

  // Divider operands: one quotient bit per cycle, dividend left-aligned
  always_ff @(posedge clk) begin
    unique case (op)
      DP_DIV_MOD: begin
        quo     <= DIV_W'(e_val) << SH_M;
        rem     <= '0;
        divisor <= DVW'(in_dur);
      end
      DP_DIV_SCALE: begin
        quo     <= prod;
        rem     <= '0;
        divisor <= DVW'(in_spd);
      end
      default: begin
        if (cnt != '0) begin
          rem <= take ? diff_rem[DVW-1:0] : trial[DVW-1:0];
          quo <= {quo[DIV_W-2:0], take};
        end
      end
    endcase
  end

  // A new division never starts over one still running
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    (op == DP_DIV_E || op == DP_DIV_MOD || op == DP_DIV_SCALE) |->
      (cnt == '0 && mcnt == '0))
    else $error("division started while divider busy");

  // Results are only taken from a finished division
  a_div_result_ready: assert property (@(posedge clk) disable iff (rst)
    (op == DP_TICK || op == DP_FREEZE || op == DP_REBASE) |-> cnt == '0)
    else $error("divider result used before it finished");

  // A tick leaves the phase inside the loop
  a_phase_in_loop: assert property (@(posedge clk) disable iff (rst)
    op == DP_TICK |=> st_phase < in_dur)
    else $error("phase outside loop length after tick");

endmodule

// ----- hdl/vsptb_ctrl.sv -----
module vsptb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  vsptb_pkg::dp_status_t status,
  output vsptb_pkg::dp_op_t     op
);
  import vsptb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_E_DIV,
    S_E_WAIT,
    S_MOD_WAIT,
    S_POS_HUND,
    S_SCALE_DIV,
    S_SCALE_WAIT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  // Sequencing of datapath operations
  always_comb begin
    state_next = state;
    op         = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = DP_CAPTURE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.cmd == CMD_CONTROL) begin
          if (!status.have || !status.pat_match) begin
            op         = DP_RESTART;
            state_next = S_FINISH;
          end else if (status.spd_same) begin
            state_next = S_FINISH;
          end else if (status.speed_zero) begin
            op         = DP_MUL_POS;
            state_next = S_POS_HUND;
          end else begin
            op         = DP_MUL_DIFF;
            state_next = S_E_DIV;
          end
        end else begin
          if (!status.have) begin
            state_next = S_FINISH;
          end else if (status.speed_zero) begin
            op         = DP_PAUSE_TICK;
            state_next = S_FINISH;
          end else begin
            op         = DP_MUL_DIFF;
            state_next = S_E_DIV;
          end
        end
      end
      S_E_DIV: begin
        op         = DP_DIV_E;
        state_next = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (!status.div_busy) begin
          if (status.cmd == CMD_CONTROL && !status.spd_zero) begin
            op         = DP_E_HUNDRED;
            state_next = S_SCALE_DIV;
          end else begin
            op         = DP_DIV_MOD;
            state_next = S_MOD_WAIT;
          end
        end
      end
      S_MOD_WAIT: begin
        if (!status.div_busy) begin
          op         = (status.cmd == CMD_CONTROL) ? DP_FREEZE : DP_TICK;
          state_next = S_FINISH;
        end
      end
      S_POS_HUND: begin
        op         = DP_POS_HUNDRED;
        state_next = S_SCALE_DIV;
      end
      S_SCALE_DIV: begin
        op         = DP_DIV_SCALE;
        state_next = S_SCALE_WAIT;
      end
      S_SCALE_WAIT: begin
        if (!status.div_busy) begin
          op         = DP_REBASE;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          op         = DP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == DP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A result appears only when an item is finished
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside finish");

  // Divider is quiet whenever the block waits for input
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !status.div_busy)
    else $error("divider running while idle");

  // The stall releases only after a result was queued or reset
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> $past(op == DP_EMIT))
    else $error("input released without emitting a result");

endmodule

// ----- dv/variable_speed_phase_timebase_core_tb.sv -----
`timescale 1ns / 1ps

module variable_speed_phase_timebase_core_tb;
  import vsptb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_PRINTED = 30;

  // One result transaction as seen on the output channel
  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] ph;
    logic [31:0] cyc;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = CMD_TICK;
  logic [31:0] now_ms = '0;
  logic [7:0]  speed_pct = '0;
  logic [7:0]  pattern_select = '0;
  logic [15:0] loop_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  action;
  logic [15:0] phase;
  logic [31:0] cycle_count;

  // Predicted timebase state
  logic        pat_valid = 1'b0;
  logic [7:0]  pat_id = '0;
  logic [31:0] t_start = '0;
  logic [15:0] ph_held = '0;
  logic [31:0] loops_done = '0;
  logic [7:0]  spd_now = '0;

  frame_t frames_due[$];

  int    errors = 0;
  int    items_sent = 0;
  int    results_seen = 0;
  int    acts_seen[4] = '{0, 0, 0, 0};
  int    cycle_no = 0;
  bit    tx_gaps = 1'b1;
  bit    rx_gaps = 1'b1;
  int    hold_reqs = 0;
  int    hold_served = 0;
  int    hold_left = 0;
  int    rx_burst = 0;

  // Stimulus timeline shared by the backpressure and random tests
  logic [31:0] wall = '0;
  logic [7:0]  cur_pat = '0;
  logic [15:0] cur_len = 16'd1000;

  variable_speed_phase_timebase_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .now_ms         (now_ms),
    .speed_pct      (speed_pct),
    .pattern_select (pattern_select),
    .loop_length    (loop_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .action         (action),
    .phase          (phase),
    .cycle_count    (cycle_count)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_no,
               frames_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    errors++;
    // keep the log short when everything goes wrong
    if (errors <= MAX_PRINTED) $display("ERROR t=%0t: %s", $time, msg);
  endtask

  // Timebase prediction for one accepted item; updates the predicted state
  function automatic frame_t advance_timebase(input logic c, input logic [31:0] t,
                                              input logic [7:0] s, input logic [7:0] p,
                                              input logic [15:0] len);
    longint unsigned dur;
    longint unsigned elapsed;
    longint unsigned pos;
    logic [31:0]     dt;
    logic [31:0]     count;
    frame_t          f;
    dur = (len == '0) ? 64'd1 : 64'(len);
    dt = t - t_start;
    elapsed = (64'(dt) * 64'(spd_now)) / PCT_SCALE;
    f.act = ACT_NONE;
    if (c == CMD_CONTROL) begin
      if (!pat_valid || p != pat_id) begin
        pat_valid = 1'b1;
        pat_id = p;
        t_start = t;
        ph_held = '0;
        loops_done = '0;
        spd_now = s;
        f.act = ACT_RESTART;
      end else if (s != spd_now) begin
        if (s == '0) begin
          // pause: freeze the phase, keep the loop count
          ph_held = 16'(elapsed % dur);
        end else if (spd_now == '0) begin
          // resume: place start so the frozen position is reached again
          pos = 64'(loops_done) * dur + 64'(ph_held);
          t_start = t - 32'((pos * PCT_SCALE) / s);
        end else begin
          t_start = t - 32'((elapsed * PCT_SCALE) / s);
        end
        spd_now = s;
      end
    end else if (pat_valid) begin
      if (spd_now == '0) begin
        f.act = ACT_REDRAW;
      end else begin
        count = 32'(elapsed / dur);
        ph_held = 16'(elapsed % dur);
        if (count != loops_done) begin
          loops_done = count;
          f.act = ACT_WRAP;
        end else begin
          f.act = ACT_REDRAW;
        end
      end
    end
    f.ph = ph_held;
    f.cyc = loops_done;
    return f;
  endfunction

  // Offer one item and wait until it is taken
  task automatic send_item(input logic c, input logic [31:0] t, input logic [7:0] s,
                           input logic [7:0] p, input logic [15:0] len);
    if (tx_gaps && $urandom_range(4, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= c;
    now_ms         <= t;
    speed_pct      <= s;
    pattern_select <= p;
    loop_length    <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_due.push_back(advance_timebase(c, t, s, p, len));
    items_sent++;
  endtask

  // Result receiver: random stall bursts, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_served = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_burst > 0) begin
      rx_burst--;
      out_stall <= 1'b1;
    end else if (rx_gaps && $urandom_range(5, 0) == 0) begin
      rx_burst = $urandom_range(15, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result action=%0d phase=%0d cycle=%0d",
                                action, phase, cycle_count));
      end else begin
        want = frames_due.pop_front();
        results_seen++;
        acts_seen[action]++;
        if (action !== want.act)
          flag_mismatch($sformatf("result %0d action %0d, want %0d",
                                  results_seen, action, want.act));
        if (phase !== want.ph)
          flag_mismatch($sformatf("result %0d phase %0d, want %0d",
                                  results_seen, phase, want.ph));
        if (cycle_count !== want.cyc)
          flag_mismatch($sformatf("result %0d cycle_count %0d, want %0d",
                                  results_seen, cycle_count, want.cyc));
      end
    end
  end

  function automatic logic [7:0] pick_speed();
    int r;
    r = $urandom_range(99, 0);
    if (r < 20) return 8'd0;
    if (r < 35) return 8'd100;
    if (r < 45) return 8'd255;
    if (r < 50) return 8'd1;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 30) return 16'd1;
    if (r < 70) return 16'($urandom_range(2000, 2));
    return 16'($urandom);
  endfunction

  // Ticks before any pattern report action none, whatever the other fields hold
  task automatic test_no_pattern();
    send_item(CMD_TICK, 32'd0, 8'hFF, 8'hFF, 16'd0);
    send_item(CMD_TICK, 32'hFFFF_FFFF, 8'd0, 8'd0, 16'hFFFF);
  endtask

  // First control restarts even for pattern 0; same settings do nothing
  task automatic test_restart();
    send_item(CMD_CONTROL, 32'd1000, 8'd100, 8'd0, 16'd1000);
    send_item(CMD_TICK, 32'd1500, 8'd0, 8'd0, 16'd1000);
    send_item(CMD_TICK, 32'd2500, 8'd0, 8'd0, 16'd1000);
    send_item(CMD_CONTROL, 32'd3000, 8'd100, 8'd0, 16'd1000);
    send_item(CMD_CONTROL, 32'd5000, 8'd100, 8'd255, 16'd1000);
  endtask

  // Speed changes: running to running, pause, resume, odd loop lengths
  task automatic test_rebase();
    send_item(CMD_CONTROL, 32'd5750, 8'd255, 8'd255, 16'd1000);
    send_item(CMD_TICK, 32'd6000, 8'd0, 8'd0, 16'd1000);
    send_item(CMD_CONTROL, 32'd6100, 8'd0, 8'd255, 16'd1000);
    send_item(CMD_TICK, 32'd9000, 8'd0, 8'd0, 16'd1000);
    send_item(CMD_CONTROL, 32'd9100, 8'd1, 8'd255, 16'd1000);
    send_item(CMD_TICK, 32'd19100, 8'd0, 8'd0, 16'd1000);
    send_item(CMD_CONTROL, 32'd19200, 8'd100, 8'd255, 16'd1000);
    send_item(CMD_TICK, 32'd20000, 8'd0, 8'd0, 16'd0);
    send_item(CMD_TICK, 32'd90000, 8'd0, 8'd0, 16'hFFFF);
  endtask

  // Time wrapping past 2^32 and a loop count that overflows 32 bits
  task automatic test_wide_values();
    send_item(CMD_CONTROL, 32'hFFFF_FF00, 8'd255, 8'd7, 16'd1);
    send_item(CMD_TICK, 32'h0000_0100, 8'd0, 8'd0, 16'd1);
    send_item(CMD_TICK, 32'hFFFF_FEFF, 8'd0, 8'd0, 16'd1);
  endtask

  // Receiver holds off while items keep coming, so the block backs up
  task automatic test_backpressure();
    cur_pat = 8'h3C;
    cur_len = 16'd700;
    wall = 32'd100000;
    hold_reqs++;
    send_item(CMD_CONTROL, wall, 8'd150, cur_pat, cur_len);
    for (int i = 0; i < 12; i++) begin
      wall += $urandom_range(500, 0);
      send_item(CMD_TICK, wall, 8'd0, 8'd0, cur_len);
    end
  endtask

  // Mostly a forward-running clock with occasional control changes
  task automatic test_random(input int n);
    int          r;
    int          rs;
    logic [15:0] len;
    for (int i = 0; i < n; i++) begin
      if (i >= n * 3 / 4) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else if (i % 40 == 0) begin
        tx_gaps = $urandom_range(3, 0) != 0;
        rx_gaps = $urandom_range(3, 0) != 0;
      end
      rs = $urandom_range(99, 0);
      if (rs < 70) wall += $urandom_range(3000, 0);
      else if (rs < 90) wall += $urandom_range(200000, 0);
      else if (rs < 98) wall += $urandom;
      len = cur_len;
      if ($urandom_range(9, 0) == 0) len = pick_length();
      r = $urandom_range(99, 0);
      if (r < 68) begin
        send_item(CMD_TICK, wall, 8'($urandom), 8'($urandom), len);
      end else if (r < 88) begin
        send_item(CMD_CONTROL, wall, pick_speed(), cur_pat, len);
      end else if (r < 95) begin
        cur_pat = 8'($urandom);
        cur_len = pick_length();
        send_item(CMD_CONTROL, wall, pick_speed(), cur_pat, cur_len);
      end else begin
        // noise: arbitrary item off the running timeline
        send_item(1'($urandom), $urandom, 8'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_no_pattern();
    test_restart();
    test_rebase();
    test_wide_values();
    test_backpressure();
    test_random(600);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items, %0d results: none %0d, redraw %0d, wrap %0d, restart %0d",
             items_sent, results_seen, acts_seen[ACT_NONE], acts_seen[ACT_REDRAW],
             acts_seen[ACT_WRAP], acts_seen[ACT_RESTART]);
    $display("covered pause/resume rebasing, time wrap, long output hold-off; %0d errors",
             errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- variable_speed_phase_timebase_core.f -----
hdl/vsptb_pkg.sv
hdl/vsptb_dpath.sv
hdl/vsptb_ctrl.sv
hdl/variable_speed_phase_timebase_core.sv
dv/variable_speed_phase_timebase_core_tb.sv
